>>> rtl/tmma_pkg.sv
// Shared constants for the trimmed mean moving average unit.
package tmma_pkg;

    // Default build sizes.
    localparam int MAX_WINDOW_DEF  = 16;
    localparam int SAMPLE_BITS_DEF = 16;

    // Window size limits and reset value.
    localparam int MIN_WINDOW   = 3;
    localparam int WINDOW_RESET = 16;

    // Register map: word index of each configuration register.
    localparam logic REG_WINDOW_SIZE = 1'b0;

    // Width of the signed sum of a window of max_window samples.
    function automatic int sum_width(input int sample_bits, input int max_window);
        return sample_bits + $clog2(max_window) + 1;
    endfunction

endpackage

>>> rtl/tmma_div.sv
// Bit-serial signed divider, quotient truncated toward zero.
module tmma_div #(
    parameter int NUM_W = tmma_pkg::sum_width(tmma_pkg::SAMPLE_BITS_DEF,
                                              tmma_pkg::MAX_WINDOW_DEF),
    parameter int DEN_W = $clog2(tmma_pkg::MAX_WINDOW_DEF + 1)
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic signed [NUM_W-1:0] num,
    input  logic        [DEN_W-1:0] den,
    output logic                    done,
    output logic signed [NUM_W-1:0] quo
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic             neg_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [NUM_W-1:0] q_reg;

    logic [DEN_W:0]   rem_sh;
    logic [DEN_W:0]   diff;
    logic             take;

    // One quotient bit per cycle: shift in the next dividend bit, try subtract.
    assign rem_sh = {rem_reg, q_reg[NUM_W-1]};
    assign diff   = rem_sh - {1'b0, den_reg};
    assign take   = (rem_sh >= {1'b0, den_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            neg_reg <= num[NUM_W-1];
            q_reg   <= num[NUM_W-1] ? $unsigned(-num) : $unsigned(num);
            rem_reg <= '0;
            den_reg <= den;
        end else if (busy_reg) begin
            rem_reg <= take ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            q_reg   <= {q_reg[NUM_W-2:0], take};
        end
    end

    assign done = done_reg;
    assign quo  = neg_reg ? -$signed(q_reg) : $signed(q_reg);

endmodule

>>> rtl/trimmed_mean_moving_average_unit.sv
// Trimmed mean moving average filter: sample ring in RAM, window scan, serial divide.
//
//  port group | direction | payload
//  -----------+-----------+-------------------------------------------------
//  s_axis     | in        | tdata: sample; tuser: restart
//  m_axis     | out       | tdata: average; tuser: window_full
//  apb        | cfg       | window_size at byte address 0 (clamped 3..MAX_WINDOW)
//
//  While the window fills, an item passes through read, update, launch, divide
//  and output; once it is full, a scan of the window through the single RAM
//  read port comes before the launch, and the divider works one bit per
//  cycle. One item is in flight at a time.
//  Reset is synchronous, active low, and needs no clearing pass: the fill
//  count marks which RAM entries hold live samples. A stalled result sits in
//  the output register while the next transaction is accepted and worked on.
module trimmed_mean_moving_average_unit #(
    parameter int MAX_WINDOW  = tmma_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = tmma_pkg::SAMPLE_BITS_DEF,
    localparam int TD_W       = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic            aclk,
    input  logic            aresetn,
    // sample [SAMPLE_BITS-1:0], zero padding above
    input  logic [TD_W-1:0] s_tdata,
    // restart [0]
    input  logic            s_tuser,
    input  logic            s_tvalid,
    output logic            s_tready,
    // average [SAMPLE_BITS-1:0], zero padding above
    output logic [TD_W-1:0] m_tdata,
    // window_full [0]
    output logic            m_tuser,
    output logic            m_tvalid,
    input  logic            m_tready,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [2:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready
);

    localparam int SW       = SAMPLE_BITS;
    localparam int WS_W     = $clog2(MAX_WINDOW + 1);
    localparam int AW       = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int SUM_W    = tmma_pkg::sum_width(SAMPLE_BITS, MAX_WINDOW);
    localparam int WS_RESET = (MAX_WINDOW < tmma_pkg::WINDOW_RESET) ?
                              MAX_WINDOW : tmma_pkg::WINDOW_RESET;

    // Sequencer codes.
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_READ   = 3'd1;
    localparam logic [2:0] ST_UPDATE = 3'd2;
    localparam logic [2:0] ST_SCAN   = 3'd3;
    localparam logic [2:0] ST_LAUNCH = 3'd4;
    localparam logic [2:0] ST_DIV    = 3'd5;
    localparam logic [2:0] ST_OUT    = 3'd6;

    // Sample ring: one write port, one registered read port.
    logic signed [SW-1:0] ring_mem [MAX_WINDOW];
    logic signed [SW-1:0] rd_data_reg;
    logic        [AW-1:0] rd_addr;
    logic                 wr_en;

    logic [2:0]              state_reg;
    logic [WS_W-1:0]         ws_reg;
    logic [WS_W-1:0]         count_reg;
    logic [AW-1:0]           slot_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic signed [SW-1:0]    x_reg;
    logic signed [SW-1:0]    hi_reg;
    logic signed [SW-1:0]    lo_reg;
    logic                    full_reg;
    logic [WS_W-1:0]         iss_reg;
    logic                    rv_reg;
    logic signed [SW-1:0]    avg_reg;
    logic                    m_full_reg;
    logic                    m_valid_reg;

    logic                    cfg_wr;
    logic [WS_W-1:0]         ws_next;
    logic                    s_acc;
    logic signed [SW-1:0]    old_val;
    logic [WS_W-1:0]         count_next;
    logic [WS_W-1:0]         slot_p1;
    logic [AW-1:0]           slot_next;
    logic                    issue;
    logic signed [SUM_W-1:0] div_num;
    logic [WS_W-1:0]         div_den;
    logic                    div_start;
    logic                    div_done;
    logic signed [SUM_W-1:0] div_quo;
    logic                    out_free;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == tmma_pkg::REG_WINDOW_SIZE);

    // Clamp the written size into the legal range.
    always_comb begin
        if (pwdata < 32'(tmma_pkg::MIN_WINDOW)) begin
            ws_next = WS_W'(tmma_pkg::MIN_WINDOW);
        end else if (pwdata > 32'(MAX_WINDOW)) begin
            ws_next = WS_W'(MAX_WINDOW);
        end else begin
            ws_next = pwdata[WS_W-1:0];
        end
    end

    assign prdata = (paddr[2] == tmma_pkg::REG_WINDOW_SIZE) ? 32'(ws_reg) : 32'd0;

    // ---------------- input side ----------------
    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;

    // ---------------- ring update arithmetic ----------------
    // Entries at or past the fill count hold no live sample: read them as zero.
    assign old_val    = (count_reg == ws_reg) ? rd_data_reg : '0;
    assign count_next = (count_reg == ws_reg) ? ws_reg : count_reg + 1'b1;
    assign slot_p1    = WS_W'(slot_reg) + 1'b1;
    assign slot_next  = (slot_p1 >= ws_reg) ? '0 : slot_p1[AW-1:0];

    // Scan issues one read per cycle while addresses remain.
    assign issue   = (state_reg == ST_SCAN) && (iss_reg < ws_reg);
    assign rd_addr = (state_reg == ST_READ) ? slot_reg : iss_reg[AW-1:0];
    assign wr_en   = (state_reg == ST_UPDATE);

    // The write in ST_UPDATE and the scan reads never share a cycle, so no
    // forwarding path is needed.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            ring_mem[slot_reg] <= x_reg;
        end
        rd_data_reg <= ring_mem[rd_addr];
    end

    // ---------------- divider ----------------
    assign div_start = (state_reg == ST_LAUNCH);
    assign div_num   = full_reg ? (sum_reg - SUM_W'(hi_reg) - SUM_W'(lo_reg)) : sum_reg;
    assign div_den   = full_reg ? (ws_reg - WS_W'(2)) : count_reg;

    tmma_div #(
        .NUM_W(SUM_W),
        .DEN_W(WS_W)
    ) u_div (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (div_start),
        .num    (div_num),
        .den    (div_den),
        .done   (div_done),
        .quo    (div_quo)
    );

    // ---------------- output register ----------------
    assign out_free = !m_valid_reg || m_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = TD_W'($unsigned(avg_reg));
    assign m_tuser  = m_full_reg;

    // ---------------- control ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            ws_reg      <= WS_W'(WS_RESET);
            count_reg   <= '0;
            slot_reg    <= '0;
            sum_reg     <= '0;
            iss_reg     <= '0;
            rv_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            rv_reg <= issue;

            // Load a finished result, or drop the one taken downstream.
            if ((state_reg == ST_OUT) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    // Size writes and restart both empty the window.
                    if (cfg_wr) begin
                        ws_reg <= ws_next;
                    end
                    if (cfg_wr || (s_acc && s_tuser)) begin
                        count_reg <= '0;
                        slot_reg  <= '0;
                        sum_reg   <= '0;
                    end
                    if (s_acc) begin
                        state_reg <= ST_READ;
                    end
                end
                ST_READ: begin
                    state_reg <= ST_UPDATE;
                end
                ST_UPDATE: begin
                    // Replace the oldest sample and advance the ring.
                    sum_reg   <= sum_reg - SUM_W'(old_val) + SUM_W'(x_reg);
                    count_reg <= count_next;
                    slot_reg  <= slot_next;
                    iss_reg   <= '0;
                    state_reg <= (count_next == ws_reg) ? ST_SCAN : ST_LAUNCH;
                end
                ST_SCAN: begin
                    if (issue) begin
                        iss_reg <= iss_reg + 1'b1;
                    end else if (!rv_reg) begin
                        state_reg <= ST_LAUNCH;
                    end
                end
                ST_LAUNCH: begin
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    if (div_done) begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    // Hold the quotient until the output register frees up.
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            x_reg <= s_tdata[SW-1:0];
        end
        if (state_reg == ST_UPDATE) begin
            full_reg <= (count_next == ws_reg);
            hi_reg   <= x_reg;
            lo_reg   <= x_reg;
        end
        // Track the largest and smallest entry as scan data returns.
        if (rv_reg) begin
            if (rd_data_reg > hi_reg) begin
                hi_reg <= rd_data_reg;
            end
            if (rd_data_reg < lo_reg) begin
                lo_reg <= rd_data_reg;
            end
        end
        if ((state_reg == ST_OUT) && out_free) begin
            avg_reg    <= div_quo[SW-1:0];
            m_full_reg <= full_reg;
        end
    end

endmodule

>>> rtl/tmma_checker.sv
// Port-level checks for the trimmed mean moving average unit, bound to the top level.
module tmma_checker #(
    parameter int MAX_WINDOW  = tmma_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = tmma_pkg::SAMPLE_BITS_DEF,
    localparam int TD_W       = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input logic            aclk,
    input logic            aresetn,
    input logic            s_tvalid,
    input logic            s_tready,
    input logic [TD_W-1:0] m_tdata,
    input logic            m_tuser,
    input logic            m_tvalid,
    input logic            m_tready,
    input logic            psel,
    input logic            penable,
    input logic            pwrite,
    input logic [2:0]      paddr,
    input logic [31:0]     pwdata,
    input logic [31:0]     prdata
);

    // One transaction in flight: ready drops right after an accept.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while an item was in flight");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // An in-range window size reads back as written.
    a_size_readback: assert property (@(posedge aclk) disable iff (!aresetn)
        (psel && penable && pwrite && (paddr[2] == tmma_pkg::REG_WINDOW_SIZE)
         && (pwdata >= 32'(tmma_pkg::MIN_WINDOW)) && (pwdata <= 32'(MAX_WINDOW)))
        |=> ((paddr[2] != tmma_pkg::REG_WINDOW_SIZE) || (prdata == $past(pwdata))))
        else $error("window size readback mismatch");

endmodule

bind trimmed_mean_moving_average_unit tmma_checker #(
    .MAX_WINDOW (MAX_WINDOW),
    .SAMPLE_BITS(SAMPLE_BITS)
) u_tmma_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata)
);

>>> tb/tb_trimmed_mean_moving_average_unit.sv
// Self-checking testbench for the trimmed mean moving average unit.
`timescale 1ns / 100ps

module tb_trimmed_mean_moving_average_unit;

    localparam int SAMPLE_W  = tmma_pkg::SAMPLE_BITS_DEF;
    localparam int RING_SIZE = tmma_pkg::MAX_WINDOW_DEF;
    localparam int TDATA_W   = ((SAMPLE_W + 7) / 8) * 8;
    localparam logic [2:0] WINDOW_SIZE_ADDR = {tmma_pkg::REG_WINDOW_SIZE, 2'b00};

    // One filter output as it leaves the master side.
    typedef struct packed {
        logic [SAMPLE_W-1:0] average;
        logic                window_full;
    } filter_result_t;

    // Trimmed mean filter predictor plus the queue of averages it still owes.
    class tmma_scoreboard;
        logic signed [SAMPLE_W-1:0] ring [RING_SIZE];
        longint                     ring_sum;
        int                         fill;
        int                         slot_ptr;
        int                         win;
        filter_result_t             owed [$];
        int                         mismatches;

        function new();
            win        = tmma_pkg::WINDOW_RESET;
            mismatches = 0;
            clear_filter();
        endfunction

        function void clear_filter();
            foreach (ring[i]) ring[i] = '0;
            ring_sum = 0;
            fill     = 0;
            slot_ptr = 0;
        endfunction

        // Clamp the written size into range; any write restarts the filter.
        function void set_window(int unsigned value);
            if (value < tmma_pkg::MIN_WINDOW)
                win = tmma_pkg::MIN_WINDOW;
            else if (value > RING_SIZE)
                win = RING_SIZE;
            else
                win = value;
            clear_filter();
        endfunction

        // Advance the predictor by one accepted sample and queue its average.
        function void note_input(logic signed [SAMPLE_W-1:0] smp, bit restart);
            int             slot;
            longint         hi;
            longint         lo;
            longint         avg;
            filter_result_t r;
            if (restart)
                clear_filter();
            if (fill < win)
                fill++;
            slot = (slot_ptr >= win) ? 0 : slot_ptr;
            ring_sum   = ring_sum - ring[slot] + smp;
            ring[slot] = smp;
            slot_ptr   = (slot + 1 >= win) ? 0 : slot + 1;
            r.window_full = (fill == win);
            if (r.window_full) begin
                hi = smp;
                lo = smp;
                for (int i = 0; i < win; i++) begin
                    if (ring[i] > hi) hi = ring[i];
                    if (ring[i] < lo) lo = ring[i];
                end
                // drop one max and one min, even if tied
                avg = (ring_sum - hi - lo) / (win - 2);
            end else begin
                avg = ring_sum / fill;
            end
            r.average = avg[SAMPLE_W-1:0];
            owed.push_back(r);
        endfunction

        function void check_result(logic [SAMPLE_W-1:0] average, logic full);
            filter_result_t e;
            if (owed.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] unexpected result: average %0d window_full %0b",
                             $realtime, $signed(average), full);
                return;
            end
            e = owed.pop_front();
            if (average !== e.average || full !== e.window_full) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] mismatch: average exp %0d got %0d, window_full exp %0b got %0b",
                             $realtime, $signed(e.average), $signed(average),
                             e.window_full, full);
            end
        endfunction

        function int pending();
            return owed.size();
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Block signals; every input starts at a known value.
    // ------------------------------------------------------------------
    logic               aclk;
    logic               aresetn  = 1'b0;
    logic [TDATA_W-1:0] s_tdata  = '0;   // sample [15:0]
    logic               s_tuser  = 1'b0; // restart [0]
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [TDATA_W-1:0] m_tdata;         // average [15:0]
    logic               m_tuser;         // window_full [0]
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic               psel     = 1'b0;
    logic               penable  = 1'b0;
    logic               pwrite   = 1'b0;
    logic [2:0]         paddr    = '0;
    logic [31:0]        pwdata   = '0;
    logic [31:0]        prdata;
    logic               pready;

    tmma_scoreboard sb;

    // Idle odds per phase: 0 means no idling, n means a burst starts 1 time in n.
    int gap_odds   = 0;
    int stall_odds = 0;

    trimmed_mean_moving_average_unit DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Hold the run to a hard ceiling far above the slowest legal run.
    initial begin
        #8_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Drop m_tready in random bursts of random length; keep it high otherwise.
    initial begin
        int left;
        left = 0;
        forever begin
            @(posedge aclk);
            if (left > 0) begin
                left--;
                m_tready <= 1'b0;
            end else if (stall_odds != 0 && $urandom_range(0, stall_odds - 1) == 0) begin
                left = $urandom_range(1, 12) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Check every result transaction against the oldest owed average.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata[SAMPLE_W-1:0], m_tuser);
    end

    // ------------------------------------------------------------------
    // Drivers. Every task returns in the time step of a rising edge.
    // ------------------------------------------------------------------

    // Offer one sample, after an optional gap, and note it once accepted.
    // s_tvalid is left high so back-to-back samples need no second assignment.
    task automatic send_sample(input logic [SAMPLE_W-1:0] smp, input bit restart);
        int gap;
        gap = 0;
        if (gap_odds != 0 && $urandom_range(0, gap_odds - 1) == 0)
            gap = $urandom_range(1, 12);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= TDATA_W'(smp);
        s_tuser  <= restart;
        do @(posedge aclk); while (!s_tready);
        sb.note_input(smp, restart);
    endtask

    // Lower s_tvalid and wait until every owed average has come back.
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
        repeat (4) @(posedge aclk);
    endtask

    // Two-phase register write: setup, then access until pready.
    task automatic write_window(input int unsigned value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= WINDOW_SIZE_ADDR;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        sb.set_window(value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    // Mix of full-range values, the two extremes, near-extremes and
    // small values that make ties for max and min likely.
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
            1, 2:    return SAMPLE_W'($signed($urandom_range(0, 8)) - 4);
            3:       return 16'h7fff - SAMPLE_W'($urandom_range(0, 3));
            4:       return 16'h8000 + SAMPLE_W'($urandom_range(0, 3));
            default: return SAMPLE_W'($urandom());
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial begin
        int unsigned sizes [9];
        int          odds  [4];
        int          phases;
        bit          quiet;

        sizes = '{16, 3, 31, 2, 17, 0, 1, 15, 4};
        odds  = '{0, 3, 6, 10};
        sb = new();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: reset size of 16, extremes, restart while filling.
        send_sample(16'h7fff, 1'b0);
        send_sample(16'h8000, 1'b0);
        send_sample(16'hffff, 1'b0);
        send_sample(16'h0000, 1'b0);
        send_sample(16'h0001, 1'b0);
        send_sample(16'h8000, 1'b1);
        send_sample(16'h7fff, 1'b0);
        drain();

        // Smallest window: three samples fill it, ties at the max and at the min.
        write_window(3);
        send_sample(16'h7fff, 1'b0);
        send_sample(16'h7fff, 1'b0);
        send_sample(16'h7fff, 1'b0);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h8000, 1'b0);
        send_sample(16'd5, 1'b0);
        send_sample(-16'sd3, 1'b0);
        send_sample(16'd5, 1'b0);
        send_sample(16'd5, 1'b0);
        send_sample(16'd7, 1'b1);
        send_sample(16'h7fff, 1'b0);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h0000, 1'b0);
        drain();

        // Below the floor clamps to 3; above the ceiling clamps to 16.
        write_window(0);
        send_sample(16'd1, 1'b0);
        send_sample(16'd2, 1'b0);
        drain();
        write_window(31);
        send_sample(16'h8000, 1'b0);
        drain();

        // Random phases: new size each phase, then a burst of samples.
        // The last two phases run with no idling on either side.
        phases = 14;
        for (int p = 0; p < phases; p++) begin
            quiet      = (p >= phases - 2);
            gap_odds   = quiet ? 0 : odds[$urandom_range(0, 3)];
            stall_odds = quiet ? 0 : odds[$urandom_range(0, 3)];
            write_window(p < 9 ? sizes[p] : $urandom_range(0, 31));
            for (int n = 0; n < 125; n++)
                send_sample(pick_sample(), $urandom_range(0, 39) == 0);
            drain();
        end

        gap_odds   = 0;
        stall_odds = 0;
        repeat (60) @(posedge aclk);

        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
